### rtl/pss_pkg.sv
// Shared types, constants and saturation helpers for the polygon span setup block.
// No dependencies; imported by the RTL, the checker and the testbench.
`default_nettype none
package pss_pkg;

    localparam int XY_W    = 24;  // vertex x/y, 8 fraction bits
    localparam int UV_W    = 17;  // texture u/v, 16 fraction bits
    localparam int COL_W   = 15;  // pixel column / row
    localparam int STEP_W  = 26;  // per-pixel step, 24 fraction bits
    localparam int OPND_W  = 26;  // multiplier operand width
    localparam int NUM_W   = 2 * OPND_W;  // product / dividend width
    localparam int DEN_W   = 26;  // signed divisor width
    localparam int DMAG_W  = DEN_W - 1;
    localparam int DIV_CYC = NUM_W / 2;  // two quotient bits per cycle
    localparam int CNT_W   = $clog2(DIV_CYC);

    // config register indexes
    localparam logic CFG_CLIP_LEFT  = 1'b0;
    localparam logic CFG_CLIP_RIGHT = 1'b1;

    localparam logic [UV_W-1:0] UV_ONE = UV_W'(65536);
    localparam int STEP_LIM = 16777216;

    typedef struct packed {
        logic                     start;
        logic signed [NUM_W-1:0]  num;
        logic signed [DEN_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [NUM_W-1:0]  quot;
    } div_rsp_t;

    function automatic logic [UV_W-1:0] sat_uv(input logic signed [NUM_W+1:0] v);
        logic [UV_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > (NUM_W+2)'(65536))
            r = UV_ONE;
        else
            r = v[UV_W-1:0];
        return r;
    endfunction

    function automatic logic signed [STEP_W-1:0] sat_step(input logic signed [NUM_W-1:0] v);
        logic signed [STEP_W-1:0] r;
        if (v > NUM_W'(STEP_LIM))
            r = STEP_W'(STEP_LIM);
        else if (v < -NUM_W'(STEP_LIM))
            r = -STEP_W'(STEP_LIM);
        else
            r = v[STEP_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/pss_div.sv
// Iterative signed divider, truncating toward zero, two quotient bits per cycle.
// Depends on pss_pkg (div_req_t, div_rsp_t, widths).
`default_nettype none
module pss_div
    import pss_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire div_req_t req,
    output div_rsp_t  rsp
);

    logic                busy_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DMAG_W-1:0]   rem_reg;
    logic [NUM_W-1:0]    quo_reg;
    logic [DMAG_W-1:0]   den_reg;
    logic                neg_reg;
    logic                done_reg;
    logic signed [NUM_W-1:0] quot_reg;

    logic [NUM_W-1:0]    num_mag;
    logic [DEN_W-1:0]    den_abs;
    logic [DMAG_W:0]     r1, r1s, r2, r2s;
    logic                ge1, ge2;
    logic [NUM_W-1:0]    q1, q2;

    assign num_mag = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
    assign den_abs = req.den[DEN_W-1] ? DEN_W'(-req.den) : DEN_W'(req.den);

    always_comb
    begin
        r1  = {rem_reg, quo_reg[NUM_W-1]};
        ge1 = r1 >= {1'b0, den_reg};
        r1s = ge1 ? r1 - {1'b0, den_reg} : r1;
        q1  = {quo_reg[NUM_W-2:0], ge1};
        r2  = {r1s[DMAG_W-1:0], q1[NUM_W-1]};
        ge2 = r2 >= {1'b0, den_reg};
        r2s = ge2 ? r2 - {1'b0, den_reg} : r2;
        q2  = {q1[NUM_W-2:0], ge2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= num_mag;
                den_reg  <= den_abs[DMAG_W-1:0];
                neg_reg  <= req.num[NUM_W-1] ^ req.den[DEN_W-1];
            end
            else if (busy_reg)
            begin
                rem_reg <= r2s[DMAG_W-1:0];
                quo_reg <= q2;
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_CYC - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    quot_reg <= neg_reg ? -$signed(q2) : $signed(q2);
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule
`default_nettype wire

### rtl/polygon_scanline_span_setup_top.sv
// Polygon scanline span setup: edge crossings, clipping and per-pixel texture steps.
// Depends on pss_pkg and pss_div (shared multiply-then-divide unit).
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------
//  edge in  | start / busy       | scan_row, ax, ay, au, av, bx, by, bu, bv, last_edge
//  config   | cfg_we, cfg_addr   | cfg_data (clip_left = 0, clip_right = 1)
//  span out | done (1-cycle beat)| span_start, span_pixels, start_u/v, step_u/v
//
// Every quotient goes through one registered multiplier and one radix-4 divider:
// multiply, launch, divide, then write-back of the quotient.
// An edge off the row or a horizontal edge needs no division, a crossing edge
// three divisions; a last edge adds the clip and step states plus up to six more
// divisions (clip u/v, steps).
// busy is high from the beat accept until the item is finished; done is a single
// cycle strobe and the receiver cannot stall it. Reset clears the clip registers
// to 0 / 1023 and marks no row open; the first edge of a row reloads the ends.
`default_nettype none
module polygon_scanline_span_setup_top
    import pss_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // config port
    input  wire logic                     cfg_we,
    input  wire logic                     cfg_addr,
    input  wire logic [COL_W-1:0]         cfg_data,
    // edge beat
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [COL_W-1:0]         scan_row,
    input  wire logic signed [XY_W-1:0]   ax,
    input  wire logic signed [XY_W-1:0]   ay,
    input  wire logic [UV_W-1:0]          au,
    input  wire logic [UV_W-1:0]          av,
    input  wire logic signed [XY_W-1:0]   bx,
    input  wire logic signed [XY_W-1:0]   by,
    input  wire logic [UV_W-1:0]          bu,
    input  wire logic [UV_W-1:0]          bv,
    input  wire logic                     last_edge,
    // span beat
    output logic                          done,
    output logic [COL_W-1:0]              span_start,
    output logic [COL_W-1:0]              span_pixels,
    output logic [UV_W-1:0]               start_u,
    output logic [UV_W-1:0]               start_v,
    output logic signed [STEP_W-1:0]      step_u,
    output logic signed [STEP_W-1:0]      step_v
);

    typedef enum logic [3:0] {
        S_IDLE, S_CLASS, S_MUL, S_DIV, S_WAIT, S_UPD, S_LAST,
        S_CLIPL, S_CLIPR, S_STEP, S_OUT
    } state_t;

    // which quotient the shared unit is working on
    typedef enum logic [3:0] {
        OP_X, OP_U, OP_V, OP_CLU, OP_CLV, OP_CRU, OP_CRV, OP_SU, OP_SV
    } op_t;

    state_t state_reg;
    op_t    op_reg;
    logic   row_open_reg;
    logic [COL_W-1:0] clip_left_reg, clip_right_reg;

    // latched edge
    logic [COL_W-1:0]       row_reg;
    logic signed [XY_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [UV_W-1:0]        au_reg, av_reg, bu_reg, bv_reg;
    logic                   last_reg;

    // span ends
    logic signed [XY_W-1:0] left_x_reg, right_x_reg, cx_reg;
    logic [UV_W-1:0]        left_u_reg, left_v_reg, right_u_reg, right_v_reg;
    logic [UV_W-1:0]        cu_reg, cv_reg;

    logic signed [NUM_W-1:0] prod_reg;

    // result
    logic                    done_reg;
    logic [COL_W-1:0]        span_start_reg, span_pixels_reg;
    logic [UV_W-1:0]         start_u_reg, start_v_reg;
    logic signed [STEP_W-1:0] step_u_reg, step_v_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic signed [XY_W-1:0]   ry, cl_fx, cr_fx;
    logic signed [XY_W:0]     len;
    logic                     hz_on_row, crosses;
    logic signed [OPND_W-1:0] mul_a, mul_b;
    logic signed [DEN_W-1:0]  den_sel;
    logic signed [NUM_W+1:0]  uv_sum;
    logic [UV_W-1:0]          uv_base;
    logic [COL_W-1:0]         p0, p1, sp;
    logic signed [NUM_W-1:0]  q;

    assign ry    = XY_W'({1'b0, row_reg, 8'd0});
    assign cl_fx = XY_W'({1'b0, clip_left_reg, 8'd0});
    assign cr_fx = XY_W'({1'b0, clip_right_reg, 8'd0});
    assign len   = (XY_W+1)'(right_x_reg) - (XY_W+1)'(left_x_reg);
    assign q     = div_rsp.quot;

    // horizontal edge on the row: ay truncated toward zero equals the row
    always_comb
    begin
        if (!ay_reg[XY_W-1])
            hz_on_row = ay_reg[XY_W-1:8] == {1'b0, row_reg};
        else
            hz_on_row = (row_reg == '0) && (ay_reg > -XY_W'(256));
        crosses = !((ay_reg < ry && by_reg < ry) || (ay_reg > ry && by_reg > ry));
    end

    // operand select for the shared multiply/divide
    always_comb
    begin
        case (op_reg)
            OP_X:
            begin
                mul_a   = OPND_W'(ry) - OPND_W'(by_reg);
                mul_b   = OPND_W'(ax_reg) - OPND_W'(bx_reg);
                den_sel = DEN_W'(ay_reg) - DEN_W'(by_reg);
            end
            OP_U, OP_V:
            begin
                mul_a   = (op_reg == OP_U) ?
                          OPND_W'({1'b0, bu_reg}) - OPND_W'({1'b0, au_reg}) :
                          OPND_W'({1'b0, bv_reg}) - OPND_W'({1'b0, av_reg});
                mul_b   = OPND_W'(ry) - OPND_W'(ay_reg);
                den_sel = DEN_W'(by_reg) - DEN_W'(ay_reg);
            end
            OP_CLU, OP_CLV:
            begin
                mul_a   = (op_reg == OP_CLU) ?
                          OPND_W'({1'b0, right_u_reg}) - OPND_W'({1'b0, left_u_reg}) :
                          OPND_W'({1'b0, right_v_reg}) - OPND_W'({1'b0, left_v_reg});
                mul_b   = OPND_W'(cl_fx) - OPND_W'(left_x_reg);
                den_sel = DEN_W'(len);
            end
            OP_CRU, OP_CRV:
            begin
                mul_a   = (op_reg == OP_CRU) ?
                          OPND_W'({1'b0, right_u_reg}) - OPND_W'({1'b0, left_u_reg}) :
                          OPND_W'({1'b0, right_v_reg}) - OPND_W'({1'b0, left_v_reg});
                mul_b   = OPND_W'(right_x_reg) - OPND_W'(cr_fx);
                den_sel = DEN_W'(len);
            end
            OP_SU, OP_SV:
            begin
                mul_a   = (op_reg == OP_SU) ?
                          OPND_W'({1'b0, right_u_reg}) - OPND_W'({1'b0, left_u_reg}) :
                          OPND_W'({1'b0, right_v_reg}) - OPND_W'({1'b0, left_v_reg});
                mul_b   = OPND_W'(65536);
                den_sel = DEN_W'(len);
            end
            default:
            begin
                mul_a   = '0;
                mul_b   = '0;
                den_sel = DEN_W'(1);
            end
        endcase
    end

    // clip write-back: left end moves forward, right end moves back
    always_comb
    begin
        case (op_reg)
            OP_CLU:  uv_base = left_u_reg;
            OP_CLV:  uv_base = left_v_reg;
            OP_CRU:  uv_base = right_u_reg;
            OP_CRV:  uv_base = right_v_reg;
            default: uv_base = '0;
        endcase
        if (op_reg == OP_CLU || op_reg == OP_CLV)
            uv_sum = (NUM_W+2)'({1'b0, uv_base}) + (NUM_W+2)'(q);
        else
            uv_sum = (NUM_W+2)'({1'b0, uv_base}) - (NUM_W+2)'(q);
    end

    // pixel span: left end is never negative here, right end may be
    always_comb
    begin
        p0 = left_x_reg[XY_W-2:8];
        p1 = right_x_reg[XY_W-2:8];
        if (right_x_reg[XY_W-1] || p1 <= p0)
            sp = '0;
        else
            sp = p1 - p0;
    end

    assign div_req.start = (state_reg == S_DIV);
    assign div_req.num   = prod_reg;
    assign div_req.den   = den_sel;

    pss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_X;
            row_open_reg   <= 1'b0;
            clip_left_reg  <= '0;
            clip_right_reg <= COL_W'(1023);
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_CLIP_LEFT:  clip_left_reg  <= cfg_data;
                    CFG_CLIP_RIGHT: clip_right_reg <= cfg_data;
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        row_reg  <= scan_row;
                        ax_reg   <= ax;
                        ay_reg   <= ay;
                        au_reg   <= au;
                        av_reg   <= av;
                        bx_reg   <= bx;
                        by_reg   <= by;
                        bu_reg   <= bu;
                        bv_reg   <= bv;
                        last_reg <= last_edge;
                        if (!row_open_reg)
                        begin
                            left_x_reg  <= cr_fx;
                            right_x_reg <= cl_fx;
                            left_u_reg  <= '0;
                            left_v_reg  <= '0;
                            right_u_reg <= '0;
                            right_v_reg <= '0;
                        end
                        row_open_reg <= 1'b1;
                        state_reg    <= S_CLASS;
                    end
                end
                S_CLASS:
                begin
                    if (ay_reg == by_reg)
                    begin
                        if (hz_on_row)
                        begin
                            if (ax_reg < bx_reg)
                            begin
                                left_x_reg  <= ax_reg;
                                left_u_reg  <= au_reg;
                                left_v_reg  <= av_reg;
                                right_x_reg <= bx_reg;
                                right_u_reg <= bu_reg;
                                right_v_reg <= bv_reg;
                            end
                            else
                            begin
                                left_x_reg  <= bx_reg;
                                left_u_reg  <= bu_reg;
                                left_v_reg  <= bv_reg;
                                right_x_reg <= ax_reg;
                                right_u_reg <= au_reg;
                                right_v_reg <= av_reg;
                            end
                        end
                        state_reg <= S_LAST;
                    end
                    else if (crosses)
                    begin
                        op_reg    <= OP_X;
                        state_reg <= S_MUL;
                    end
                    else
                        state_reg <= S_LAST;
                end
                S_MUL:
                begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_DIV;
                end
                S_DIV:
                    state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        case (op_reg)
                            OP_X:
                            begin
                                cx_reg    <= bx_reg + q[XY_W-1:0];
                                op_reg    <= OP_U;
                                state_reg <= S_MUL;
                            end
                            OP_U:
                            begin
                                cu_reg    <= au_reg + q[UV_W-1:0];
                                op_reg    <= OP_V;
                                state_reg <= S_MUL;
                            end
                            OP_V:
                            begin
                                cv_reg    <= av_reg + q[UV_W-1:0];
                                state_reg <= S_UPD;
                            end
                            OP_CLU:
                            begin
                                left_u_reg <= sat_uv(uv_sum);
                                op_reg     <= OP_CLV;
                                state_reg  <= S_MUL;
                            end
                            OP_CLV:
                            begin
                                left_v_reg <= sat_uv(uv_sum);
                                left_x_reg <= cl_fx;
                                state_reg  <= S_CLIPR;
                            end
                            OP_CRU:
                            begin
                                right_u_reg <= sat_uv(uv_sum);
                                op_reg      <= OP_CRV;
                                state_reg   <= S_MUL;
                            end
                            OP_CRV:
                            begin
                                right_v_reg <= sat_uv(uv_sum);
                                right_x_reg <= cr_fx;
                                state_reg   <= S_STEP;
                            end
                            OP_SU:
                            begin
                                step_u_reg <= sat_step(q);
                                op_reg     <= OP_SV;
                                state_reg  <= S_MUL;
                            end
                            OP_SV:
                            begin
                                step_v_reg <= sat_step(q);
                                state_reg  <= S_OUT;
                            end
                            default:
                                state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_UPD:
                begin
                    // strictly beyond the current end
                    if (cx_reg < left_x_reg)
                    begin
                        left_x_reg <= cx_reg;
                        left_u_reg <= cu_reg;
                        left_v_reg <= cv_reg;
                    end
                    if (cx_reg > right_x_reg)
                    begin
                        right_x_reg <= cx_reg;
                        right_u_reg <= cu_reg;
                        right_v_reg <= cv_reg;
                    end
                    state_reg <= S_LAST;
                end
                S_LAST:
                begin
                    if (last_reg)
                    begin
                        row_open_reg <= 1'b0;
                        state_reg    <= S_CLIPL;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_CLIPL:
                begin
                    if (left_x_reg < cl_fx)
                    begin
                        if (len > 0)
                        begin
                            op_reg    <= OP_CLU;
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            left_x_reg <= cl_fx;
                            state_reg  <= S_CLIPR;
                        end
                    end
                    else
                        state_reg <= S_CLIPR;
                end
                S_CLIPR:
                begin
                    if (right_x_reg > cr_fx)
                    begin
                        if (len > 0)
                        begin
                            op_reg    <= OP_CRU;
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            right_x_reg <= cr_fx;
                            state_reg   <= S_STEP;
                        end
                    end
                    else
                        state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    span_start_reg  <= p0;
                    span_pixels_reg <= sp;
                    start_u_reg     <= (left_u_reg > UV_ONE) ? UV_ONE : left_u_reg;
                    start_v_reg     <= (left_v_reg > UV_ONE) ? UV_ONE : left_v_reg;
                    step_u_reg      <= '0;
                    step_v_reg      <= '0;
                    if (sp != '0)
                    begin
                        op_reg    <= OP_SU;
                        state_reg <= S_MUL;
                    end
                    else
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign span_start  = span_start_reg;
    assign span_pixels = span_pixels_reg;
    assign start_u     = start_u_reg;
    assign start_v     = start_v_reg;
    assign step_u      = step_u_reg;
    assign step_v      = step_v_reg;

endmodule
`default_nettype wire

### rtl/pss_checker.sv
// Port-level checks for polygon_scanline_span_setup_top, attached by bind.
// Depends on pss_pkg widths.
`default_nettype none
module pss_checker
    import pss_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     start,
    input wire logic                     busy,
    input wire logic                     done,
    input wire logic [COL_W-1:0]         span_pixels,
    input wire logic [UV_W-1:0]          start_u,
    input wire logic [UV_W-1:0]          start_v,
    input wire logic signed [STEP_W-1:0] step_u,
    input wire logic signed [STEP_W-1:0] step_v
);

    // an accepted beat always keeps the block busy for the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // the result beat is issued as the block goes idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // no two result beats back to back: each item passes S_CLASS and S_LAST before S_OUT
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // empty span carries zero steps
    a_empty_step: assert property (@(posedge clk) disable iff (!rst_n)
        (done && span_pixels == '0) |-> (step_u == '0 && step_v == '0))
        else $error("nonzero step on empty span");

    // start texture coordinates saturated to one
    a_uv_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (start_u <= UV_ONE && start_v <= UV_ONE))
        else $error("start u/v above one");

endmodule

bind polygon_scanline_span_setup_top pss_checker u_pss_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .span_pixels (span_pixels),
    .start_u     (start_u),
    .start_v     (start_v),
    .step_u      (step_u),
    .step_v      (step_v)
);
`default_nettype wire

### test/testbench.sv
// Testbench for polygon_scanline_span_setup_top: edge beats in, span beats out.
// Depends on pss_pkg and the RTL; carries its own span predictor and scoreboard.
`timescale 1ns / 1ps
module testbench;
    import pss_pkg::*;

    localparam int   SETTLE_CYCLES  = 400;        // longer than the longest last edge
    localparam int   CYCLE_LIMIT    = 3000000;

    typedef struct {
        logic [COL_W-1:0]        row;
        logic signed [XY_W-1:0]  ax, ay, bx, by;
        logic [UV_W-1:0]         au, av, bu, bv;
        logic                    last;
    } edge_beat_t;

    typedef struct {
        logic [COL_W-1:0]         start_col;
        logic [COL_W-1:0]         pixels;
        logic [UV_W-1:0]          u0, v0;
        logic signed [STEP_W-1:0] du, dv;
    } span_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_addr = CFG_CLIP_LEFT;
    logic [COL_W-1:0] cfg_data = '0;
    logic start = 1'b0;
    logic busy;
    logic [COL_W-1:0] scan_row = '0;
    logic signed [XY_W-1:0] ax = '0, ay = '0, bx = '0, by = '0;
    logic [UV_W-1:0] au = '0, av = '0, bu = '0, bv = '0;
    logic last_edge = 1'b0;
    logic done;
    logic [COL_W-1:0] span_start, span_pixels;
    logic [UV_W-1:0] start_u, start_v;
    logic signed [STEP_W-1:0] step_u, step_v;

    polygon_scanline_span_setup_top uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .scan_row(scan_row), .ax(ax), .ay(ay), .au(au), .av(av),
        .bx(bx), .by(by), .bu(bu), .bv(bv), .last_edge(last_edge),
        .done(done), .span_start(span_start), .span_pixels(span_pixels),
        .start_u(start_u), .start_v(start_v), .step_u(step_u), .step_v(step_v)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Span predictor: its own copy of clip registers and the two row ends.
    // ------------------------------------------------------------------
    longint clip_l = 0, clip_r = 1023;
    longint lft_x, lft_u, lft_v, rgt_x, rgt_u, rgt_v;
    bit     row_active = 1'b0;

    edge_beat_t pending_edges[$];
    span_beat_t expected_spans[$];
    int         mismatches = 0;
    int         idle_pct = 10;
    longint     cycles = 0;

    function automatic longint px_trunc(longint v);
        return v >= 0 ? v / 256 : -((-v) / 256);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void reload_ends();
        // left starts at the right bound and vice versa so any crossing wins
        lft_x = clip_r * 256;
        rgt_x = clip_l * 256;
        lft_u = 0; lft_v = 0; rgt_u = 0; rgt_v = 0;
    endfunction

    task automatic predict_edge(input edge_beat_t e);
        longint row, ry, cl, cr, xa, ya, ua, va, xb, yb, ub, vb;
        longint cx, cu, cv, len, sp, p0, p1, du, dv;
        span_beat_t s;
        row = longint'(e.row);
        xa = longint'(e.ax); ya = longint'(e.ay);
        xb = longint'(e.bx); yb = longint'(e.by);
        ua = longint'(e.au); va = longint'(e.av);
        ub = longint'(e.bu); vb = longint'(e.bv);
        ry = row * 256;
        cl = clip_l * 256;
        cr = clip_r * 256;
        du = 0; dv = 0;
        if (!row_active)
        begin
            reload_ends();
            row_active = 1'b1;
        end
        if (ya == yb)
        begin
            // horizontal edge: only counts when it lies on this row
            if (px_trunc(ya) == row)
            begin
                if (xa < xb)
                begin
                    lft_x = xa; lft_u = ua; lft_v = va;
                    rgt_x = xb; rgt_u = ub; rgt_v = vb;
                end
                else
                begin
                    lft_x = xb; lft_u = ub; lft_v = vb;
                    rgt_x = xa; rgt_u = ua; rgt_v = va;
                end
            end
        end
        else if (!((ya < ry && yb < ry) || (ya > ry && yb > ry)))
        begin
            cx = xb + (ry - yb) * (xa - xb) / (ya - yb);
            cu = ua + (ub - ua) * (ry - ya) / (yb - ya);
            cv = va + (vb - va) * (ry - ya) / (yb - ya);
            if (cx < lft_x)
            begin
                lft_x = cx; lft_u = cu; lft_v = cv;
            end
            if (cx > rgt_x)
            begin
                rgt_x = cx; rgt_u = cu; rgt_v = cv;
            end
        end
        if (!e.last)
            return;
        row_active = 1'b0;
        if (lft_x < cl)
        begin
            len = rgt_x - lft_x;
            if (len > 0)
            begin
                lft_u = clamp(lft_u + (rgt_u - lft_u) * (cl - lft_x) / len, 0, 65536);
                lft_v = clamp(lft_v + (rgt_v - lft_v) * (cl - lft_x) / len, 0, 65536);
            end
            lft_x = cl;
        end
        if (rgt_x > cr)
        begin
            len = rgt_x - lft_x;
            if (len > 0)
            begin
                rgt_u = clamp(rgt_u - (rgt_u - lft_u) * (rgt_x - cr) / len, 0, 65536);
                rgt_v = clamp(rgt_v - (rgt_v - lft_v) * (rgt_x - cr) / len, 0, 65536);
            end
            rgt_x = cr;
        end
        p0 = px_trunc(lft_x);
        p1 = px_trunc(rgt_x);
        sp = p1 - p0;
        if (sp < 0)
            sp = 0;
        len = rgt_x - lft_x;
        if (sp > 0 && len > 0)
        begin
            du = clamp((rgt_u - lft_u) * 65536 / len, -STEP_LIM, STEP_LIM);
            dv = clamp((rgt_v - lft_v) * 65536 / len, -STEP_LIM, STEP_LIM);
        end
        s.start_col = COL_W'(clamp(p0, 0, 32767));
        s.pixels    = COL_W'(clamp(sp, 0, 32767));
        s.u0        = UV_W'(clamp(lft_u, 0, 65536));
        s.v0        = UV_W'(clamp(lft_v, 0, 65536));
        s.du        = STEP_W'(du);
        s.dv        = STEP_W'(dv);
        expected_spans.push_back(s);
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Driver: start stays up until the beat is taken (busy low at the edge).
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        edge_beat_t nxt;
        if (rst_n)
        begin
            if (start && !busy)
                predict_edge('{scan_row, ax, ay, bx, by, au, av, bu, bv, last_edge});
            if (start && busy)
                start <= 1'b1;
            else if (pending_edges.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                nxt = pending_edges.pop_front();
                scan_row <= nxt.row;
                ax <= nxt.ax; ay <= nxt.ay; bx <= nxt.bx; by <= nxt.by;
                au <= nxt.au; av <= nxt.av; bu <= nxt.bu; bv <= nxt.bv;
                last_edge <= nxt.last;
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: every done beat is checked against the oldest predicted span.
    always @(posedge clk)
    begin
        span_beat_t s;
        if (rst_n && done)
        begin
            if (expected_spans.size() == 0)
                report_mismatch("span beat with nothing expected");
            else
            begin
                s = expected_spans.pop_front();
                if (span_start !== s.start_col)
                    report_mismatch($sformatf("span_start %0d exp %0d", span_start, s.start_col));
                if (span_pixels !== s.pixels)
                    report_mismatch($sformatf("span_pixels %0d exp %0d", span_pixels, s.pixels));
                if (start_u !== s.u0)
                    report_mismatch($sformatf("start_u %0d exp %0d", start_u, s.u0));
                if (start_v !== s.v0)
                    report_mismatch($sformatf("start_v %0d exp %0d", start_v, s.v0));
                if (step_u !== s.du)
                    report_mismatch($sformatf("step_u %0d exp %0d", step_u, s.du));
                if (step_v !== s.dv)
                    report_mismatch($sformatf("step_v %0d exp %0d", step_v, s.dv));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic signed [XY_W-1:0] fit_xy(longint v);
        return XY_W'(clamp(v, -8388608, 8388607));
    endfunction

    function automatic logic [UV_W-1:0] rand_uv();
        // mostly legal texture coords, now and then the out-of-range top
        return ($urandom_range(0, 9) == 0) ? UV_W'($urandom) : UV_W'($urandom_range(0, 65536));
    endfunction

    function automatic longint rand_x();
        return longint'($urandom_range(0, 33500)) * 256 - 1500 * 256
               + longint'($urandom_range(0, 255));
    endfunction

    task automatic queue_edge(input logic [COL_W-1:0] r, input longint xa, ya, xb, yb,
                              input logic lst);
        edge_beat_t e;
        e.row = r;
        e.ax = fit_xy(xa); e.ay = fit_xy(ya);
        e.bx = fit_xy(xb); e.by = fit_xy(yb);
        e.au = rand_uv(); e.av = rand_uv(); e.bu = rand_uv(); e.bv = rand_uv();
        e.last = lst;
        pending_edges.push_back(e);
    endtask

    // one polygon's edges for a row: crossings, plus the odd horizontal, miss or raw noise edge
    task automatic queue_polygon();
        int n, kind;
        longint ry, ya, yb;
        logic [COL_W-1:0] r;
        r = ($urandom_range(0, 7) == 0) ? COL_W'($urandom) : COL_W'($urandom_range(0, 1200));
        ry = longint'(r) * 256;
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
        begin
            kind = $urandom_range(0, 9);
            ya = ry - $urandom_range(0, 4000);
            yb = ry + $urandom_range(0, 4000);
            if (kind < 6)
            begin
                if ($urandom_range(0, 1))
                    queue_edge(r, rand_x(), ya, rand_x(), yb, i == n - 1);
                else
                    queue_edge(r, rand_x(), yb, rand_x(), ya, i == n - 1);
            end
            else if (kind < 8)
            begin
                ya = ry + $urandom_range(0, 255);
                queue_edge(r, rand_x(), ya, rand_x(), ya, i == n - 1);
            end
            else if (kind < 9)
                queue_edge(r, rand_x(), ry + 300 + $urandom_range(0, 900),
                           rand_x(), ry + 300 + $urandom_range(0, 900), i == n - 1);
            else
                // raw noise over the whole field ranges
                queue_edge(COL_W'($urandom), longint'($signed(XY_W'($urandom))),
                           longint'($signed(XY_W'($urandom))),
                           longint'($signed(XY_W'($urandom))),
                           longint'($signed(XY_W'($urandom))), i == n - 1);
        end
    endtask

    // blocks until the block is idle: queue drained, all spans in, tail settled
    task automatic wait_idle();
        while (pending_edges.size() != 0 || start || expected_spans.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= COL_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_CLIP_LEFT)
            clip_l = value;
        else
            clip_r = value;
    endtask

    initial
    begin
        int lefts[6];
        int rights[6];
        lefts  = '{0, 0, 32767, 100, 0, 512};
        rights = '{32767, 0, 0, 200, 1023, 900};
        reload_ends();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed edges under the reset clip window
        queue_edge(0, -8388608, -8388608, 8388607, 8388607, 1'b1);    // full-range crossing
        queue_edge(5, 10 * 256, 5 * 256 + 7, 20 * 256, 5 * 256 + 7, 1'b1); // horizontal on row
        queue_edge(5, 30 * 256, 5 * 256, 30 * 256, 5 * 256, 1'b1);    // horizontal, equal x
        queue_edge(5, 30 * 256, 9 * 256, 40 * 256, 9 * 256, 1'b1);    // horizontal off row
        queue_edge(5, 0, 7 * 256, 100, 9 * 256, 1'b1);                // entirely below row
        queue_edge(9, 0, 1, 100, 2, 1'b1);                            // entirely above row
        queue_edge(3, -500 * 256, 0, 2000 * 256, 10 * 256, 1'b0);     // clipped on the right
        queue_edge(3, 40 * 256, 10 * 256, 2000 * 256, 0, 1'b1);
        queue_edge(32767, 0, 8388607, 8388607, 8388352, 1'b1);        // top row
        queue_edge(2, 50 * 256, 2 * 256, 50 * 256, 9 * 256, 1'b0);    // vertex on row
        queue_edge(2, 50 * 256, 2 * 256, 50 * 256, 0, 1'b1);          // same x twice: empty span
        for (int i = 0; i < 4; i++)
            queue_polygon();
        wait_idle();

        // the pause before each register write also covers draining the pipe
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_CLIP_LEFT, lefts[ph]);
            write_reg(CFG_CLIP_RIGHT, rights[ph]);
            idle_pct = (ph < 2) ? 10 : ((ph < 4) ? 63 : 0);
            while (pending_edges.size() < 330)
                queue_polygon();
            wait_idle();
        end

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
